FILE: rtl/tse_pkg.sv
// shared types and constants of the table search engine
`default_nettype none

package tse_pkg;

    localparam int DEPTH     = 512;
    localparam int AW        = $clog2(DEPTH);
    localparam int NW        = $clog2(DEPTH + 1);
    localparam int CFG_W     = 10;
    localparam int IW        = $clog2(DEPTH + (2 ** CFG_W));
    localparam int DW        = 32;
    localparam int SLOT_W    = 9;
    localparam int POS_W     = 9;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK   = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] ENTRIES_RST = CFG_W'(512);
    localparam logic [CFG_W-1:0] BLOCK_RST   = CFG_W'(22);

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_BINARY = 2'd2,
        MODE_JUMP   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_WRITE,
        DP_LOAD,
        DP_SCAN,
        DP_BIN_ISSUE,
        DP_BIN_CMP,
        DP_JMP_ISSUE,
        DP_JMP_STEP,
        DP_SCAN_BLK,
        DP_SCAN_TAIL,
        DP_MISS
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic scan_hit;
        logic scan_end;
        logic bin_empty;
        logic bin_hit;
        logic jmp_more;
        logic ge;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/tse_ctrl.sv
// search sequencer: walks linear, binary and jump searches over the datapath
`default_nettype none

module tse_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          i_mode,
    input  wire tse_pkg::t_dp_status i_status,
    output logic                     busy,
    output logic                     o_valid,
    output tse_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BISS,
        ST_BCMP,
        ST_JISS,
        ST_JCMP,
        ST_TCMP
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_valid;
    logic           n_valid;
    tse_pkg::t_mode mode;

    assign mode    = tse_pkg::t_mode'(i_mode);
    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        o_cmd.op = tse_pkg::DP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (mode == tse_pkg::MODE_WRITE) begin
                        o_cmd.op = tse_pkg::DP_WRITE;
                    end else if (i_status.n_zero) begin
                        o_cmd.op = tse_pkg::DP_MISS;
                        n_valid  = 1'b1;
                    end else begin
                        o_cmd.op = tse_pkg::DP_LOAD;
                        unique case (mode)
                            tse_pkg::MODE_LINEAR: n_state = ST_SCAN;
                            tse_pkg::MODE_BINARY: n_state = ST_BISS;
                            default:              n_state = ST_JISS;
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.op = tse_pkg::DP_SCAN;
                if (i_status.scan_hit || i_status.scan_end) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_BISS: begin
                if (i_status.bin_empty) begin
                    o_cmd.op = tse_pkg::DP_MISS;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    o_cmd.op = tse_pkg::DP_BIN_ISSUE;
                    n_state  = ST_BCMP;
                end
            end
            ST_BCMP: begin
                o_cmd.op = tse_pkg::DP_BIN_CMP;
                if (i_status.bin_hit) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_BISS;
                end
            end
            ST_JISS: begin
                o_cmd.op = tse_pkg::DP_JMP_ISSUE;
                n_state  = i_status.jmp_more ? ST_JCMP : ST_TCMP;
            end
            ST_JCMP: begin
                if (i_status.ge) begin
                    o_cmd.op = tse_pkg::DP_SCAN_BLK;
                    n_state  = ST_SCAN;
                end else begin
                    o_cmd.op = tse_pkg::DP_JMP_STEP;
                    n_state  = ST_JISS;
                end
            end
            ST_TCMP: begin
                if (i_status.ge) begin
                    o_cmd.op = tse_pkg::DP_SCAN_TAIL;
                    n_state  = ST_SCAN;
                end else begin
                    o_cmd.op = tse_pkg::DP_MISS;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tse_dp.sv
// table memory, search pointers, key compare and result registers
`default_nettype none

module tse_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire tse_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [tse_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic signed [tse_pkg::DW-1:0]     i_value,
    input  wire logic [tse_pkg::CFG_W-1:0]         i_entries,
    input  wire logic [tse_pkg::CFG_W-1:0]         i_block,
    output tse_pkg::t_dp_status                    o_status,
    output logic                                   o_found,
    output logic [tse_pkg::POS_W-1:0]              o_position
);

    logic [tse_pkg::DW-1:0]           r_mem [tse_pkg::DEPTH];
    logic signed [tse_pkg::DW-1:0]    r_rd_data;
    logic signed [tse_pkg::DW-1:0]    r_key;
    logic [tse_pkg::NW-1:0]           r_ptr;
    logic [tse_pkg::NW-1:0]           r_hi;
    logic                             r_pend;
    logic [tse_pkg::AW-1:0]           r_pend_idx;
    logic signed [tse_pkg::NW:0]      r_left;
    logic signed [tse_pkg::NW:0]      r_right;
    logic [tse_pkg::AW-1:0]           r_mid;
    logic [tse_pkg::IW-1:0]           r_i;
    logic                             r_found;
    logic [tse_pkg::AW-1:0]           r_pos;

    logic [tse_pkg::NW-1:0]           n_eff;
    logic [tse_pkg::NW-1:0]           n_last;
    logic [tse_pkg::CFG_W-1:0]        h_eff;
    logic [tse_pkg::IW-1:0]           blk_lo;
    logic [tse_pkg::IW-1:0]           blk_hi;
    logic [tse_pkg::NW:0]             bin_sum;
    logic [tse_pkg::AW-1:0]           mid;
    logic [tse_pkg::AW-1:0]           rd_addr;
    logic                             ptr_in;
    logic                             wr_en;

    // entries in use saturate at the table depth, zero block size acts as one
    assign n_eff   = (32'(i_entries) > 32'(tse_pkg::DEPTH)) ?
                     tse_pkg::NW'(tse_pkg::DEPTH) : tse_pkg::NW'(i_entries);
    assign n_last  = n_eff - tse_pkg::NW'(1);
    assign h_eff   = (i_block == '0) ? tse_pkg::CFG_W'(1) : i_block;
    assign blk_lo  = r_i - tse_pkg::IW'(h_eff);
    assign blk_hi  = r_i - tse_pkg::IW'(1);
    assign bin_sum = r_left + r_right;
    assign mid     = bin_sum[tse_pkg::AW:1];
    assign ptr_in  = (r_ptr <= r_hi);
    assign wr_en   = (i_cmd.op == tse_pkg::DP_WRITE) &&
                     (32'(i_slot) < 32'(tse_pkg::DEPTH));

    assign o_status.n_zero    = (n_eff == '0);
    assign o_status.scan_hit  = r_pend && (r_rd_data == r_key);
    assign o_status.scan_end  = !r_pend && !ptr_in;
    assign o_status.bin_empty = (r_left > r_right);
    assign o_status.bin_hit   = (r_rd_data == r_key);
    assign o_status.jmp_more  = (r_i < tse_pkg::IW'(n_eff));
    assign o_status.ge        = (r_rd_data >= r_key);

    assign o_found    = r_found;
    assign o_position = tse_pkg::POS_W'(r_pos);

    always_comb begin
        unique case (i_cmd.op)
            tse_pkg::DP_SCAN:      rd_addr = r_ptr[tse_pkg::AW-1:0];
            tse_pkg::DP_BIN_ISSUE: rd_addr = mid;
            tse_pkg::DP_JMP_ISSUE: rd_addr = o_status.jmp_more ?
                                             blk_hi[tse_pkg::AW-1:0] :
                                             n_last[tse_pkg::AW-1:0];
            default:               rd_addr = '0;
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[tse_pkg::AW'(i_slot)] <= i_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else begin
            unique case (i_cmd.op)
                tse_pkg::DP_LOAD: begin
                    r_key   <= i_value;
                    r_ptr   <= '0;
                    r_hi    <= n_last;
                    r_pend  <= 1'b0;
                    r_left  <= '0;
                    r_right <= $signed({1'b0, n_eff}) - (tse_pkg::NW + 1)'(1);
                    r_i     <= tse_pkg::IW'(h_eff);
                end
                tse_pkg::DP_SCAN: begin
                    // compare the entry read last cycle while the next read goes out
                    if (o_status.scan_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_pend_idx;
                    end else if (o_status.scan_end) begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                    end
                    r_pend     <= ptr_in;
                    r_pend_idx <= r_ptr[tse_pkg::AW-1:0];
                    if (ptr_in) begin
                        r_ptr <= r_ptr + tse_pkg::NW'(1);
                    end
                end
                tse_pkg::DP_BIN_ISSUE: begin
                    r_mid <= mid;
                end
                tse_pkg::DP_BIN_CMP: begin
                    if (r_key < r_rd_data) begin
                        r_right <= $signed({1'b0, tse_pkg::NW'(r_mid)}) -
                                   (tse_pkg::NW + 1)'(1);
                    end else if (r_rd_data < r_key) begin
                        r_left <= $signed({1'b0, tse_pkg::NW'(r_mid)}) +
                                  (tse_pkg::NW + 1)'(1);
                    end else begin
                        r_found <= 1'b1;
                        r_pos   <= r_mid;
                    end
                end
                tse_pkg::DP_JMP_STEP: begin
                    r_i <= r_i + tse_pkg::IW'(h_eff);
                end
                tse_pkg::DP_SCAN_BLK: begin
                    r_ptr  <= blk_lo[tse_pkg::NW-1:0];
                    r_hi   <= blk_hi[tse_pkg::NW-1:0];
                    r_pend <= 1'b0;
                end
                tse_pkg::DP_SCAN_TAIL: begin
                    r_ptr  <= blk_lo[tse_pkg::NW-1:0];
                    r_hi   <= n_last;
                    r_pend <= 1'b0;
                end
                tse_pkg::DP_MISS: begin
                    r_found <= 1'b0;
                    r_pos   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/table_search_engine_unit.sv
// top level of the table search engine: config registers, sequencer and datapath
//
// A table of 512 signed 32-bit words, loaded entry by entry, answers
// linear, binary and jump searches over entries 0 .. entries_in_use-1.
// Requests: drive i_mode, i_slot and i_value with start; the request is
// taken on a clock edge where start is high and busy is low.
// Write requests (mode 0) store i_value at i_slot, give no result and
// leave busy low, so one write can be taken every cycle while idle.
// A search with entries_in_use above zero raises busy until it ends, then
// o_valid pulses for one cycle with o_found and o_position; o_position is
// zero on a miss. The receiver cannot stall: the result is gone afterwards.
// Search steps, n = entries in use, h = block size:
//   linear: one table read per cycle from entry 0, up to entry n-1
//   binary: each probe reads the middle entry, then compares it with the key
//   jump:   reads the last entry of each block, then scans up to h entries
// The single read port of the table memory paces these steps.
// Config port: i_cfg_index 0 is entries_in_use, 1 is block_size; o_cfg_ready
// is always high. Write config only while no search is running.
// Reset sets entries_in_use to 512 and block_size to 22; table contents are
// undefined until written, and no clearing pass runs.
`default_nettype none

module table_search_engine_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [tse_pkg::SLOT_W-1:0]        i_slot,
    input  wire logic signed [tse_pkg::DW-1:0]     i_value,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic [tse_pkg::POS_W-1:0]              o_position,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tse_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [tse_pkg::CFG_W-1:0] r_entries;
    logic [tse_pkg::CFG_W-1:0] r_block;
    tse_pkg::t_dp_cmd          cmd;
    tse_pkg::t_dp_status       status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= tse_pkg::ENTRIES_RST;
            r_block   <= tse_pkg::BLOCK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tse_pkg::REG_ENTRIES) begin
                r_entries <= i_cfg_data;
            end else if (i_cfg_index == tse_pkg::REG_BLOCK) begin
                r_block <= i_cfg_data;
            end
        end
    end

    tse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    tse_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_slot     (i_slot),
        .i_value    (i_value),
        .i_entries  (r_entries),
        .i_block    (r_block),
        .o_status   (status),
        .o_found    (o_found),
        .o_position (o_position)
    );

    // a result only follows a search request or a running search
    a_valid_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start || busy))
        else $error("result strobe without a search");

    // the result cycle returns the sequencer to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy during result cycle");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_position == '0))
        else $error("miss with nonzero position");

    // write requests complete at once with no result
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == tse_pkg::MODE_WRITE)) |=> (!busy && !o_valid))
        else $error("write request caused busy or a result");

endmodule

`default_nettype wire
